// ===== hw/rtl/huffman_code_bit_packer_macros.svh =====
// Assertion macros shared by the checker of the prefix-code bit packer.
// No dependencies; the including scope must provide clk and rst.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Checked on every rising edge outside reset.
`define HCBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hcbp: assertion failed");

// Checked on every rising edge, reset included.
`define HCBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hcbp: reset assertion failed");

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
// Shared constants, types and action codes of the prefix-code bit packer.
// No dependencies.
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  // Fixed field widths of the input and output beats.
  localparam int ACTION_W = 2;
  localparam int SYMBOL_W = 8;
  localparam int CODE_IN_W = 32;
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;

  // Seven pending bits plus the longest code.
  localparam int ACC_W = MAX_CODE_LEN + 7;
  localparam int WORD_W = ((ACC_W + 7) / 8) * 8;
  localparam int TOT_W = $clog2(WORD_W + 1);
  localparam int MAX_BYTES = (MAX_CODE_LEN + 7) / 8;
  localparam int NB_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // One packed group of output bytes, first byte in the top bits of word.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic [NB_W-1:0]   nbytes;
    logic              last;
  } push_t;

endpackage

// ===== hw/rtl/hcbp_in_if.sv =====
// Input channel of the prefix-code bit packer: handshake and item payload.
// No dependencies.
interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  symbol;
  logic [31:0] code_bits;
  logic [5:0]  code_length;

  modport source (output valid, action, symbol, code_bits, code_length, input ready);
  modport sink (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

// ===== hw/rtl/hcbp_out_if.sv =====
// Output channel of the prefix-code bit packer: handshake and byte payload.
// No dependencies.
interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== hw/rtl/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hcbp_packer.sv =====
// Bit packer stage: appends looked-up codes to pending bits, forms bytes, pads on flush.
// Depends on hcbp_pkg.
module hcbp_packer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s1_valid,
  input  logic [hcbp_pkg::ACTION_W-1:0]   s1_action,
  input  logic                            s1_in_range,
  input  logic [hcbp_pkg::ENTRY_W-1:0]    entry,
  output hcbp_pkg::push_t                 push
);
  import hcbp_pkg::*;

  logic [6:0]              pending_bits;
  logic [2:0]              pending_count;
  logic [6:0]              pending_bits_next;
  logic [2:0]              pending_count_next;
  logic [LEN_W-1:0]        len;
  logic [MAX_CODE_LEN-1:0] code;
  logic [ACC_W-1:0]        acc;
  logic [TOT_W-1:0]        total;
  logic [WORD_W-1:0]       enc_word;
  logic [BYTE_W-1:0]       flush_byte;

  assign len  = (entry[LEN_W-1:0] > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                           : entry[LEN_W-1:0];
  assign code = entry[ENTRY_W-1:LEN_W];
  assign acc  = (ACC_W'(pending_bits) << len) | ACC_W'(code);
  assign total = TOT_W'(pending_count) + TOT_W'(len);

  // Left-align the stream so the oldest bit sits in the top bit of the word.
  assign enc_word   = WORD_W'(acc) << (TOT_W'(WORD_W) - total);
  assign flush_byte = {pending_bits, 1'b0} << (3'd7 - pending_count);

  always_comb begin
    push               = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (s1_valid) begin
      case (s1_action)
        ACT_ENCODE: begin
          if (s1_in_range && len != '0) begin
            push.valid         = (total >= TOT_W'(8));
            push.word          = enc_word;
            push.nbytes        = NB_W'(total >> 3);
            push.last          = 1'b0;
            pending_count_next = total[2:0];
            pending_bits_next  = acc[6:0] & ~(7'h7f << total[2:0]);
          end
        end
        ACT_FLUSH: begin
          push.valid         = (pending_count != '0);
          push.word          = {flush_byte, {(WORD_W-BYTE_W){1'b0}}};
          push.nbytes        = NB_W'(1);
          push.last          = 1'b1;
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== hw/rtl/hcbp_out_fifo.sv =====
// Output queue of byte groups and the serializer that sends them one byte per beat.
// Depends on hcbp_pkg and hcbp_out_if.
module hcbp_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  hcbp_pkg::push_t            push,
  output logic [hcbp_pkg::CNT_W-1:0] level,
  hcbp_out_if.source                 rsp
);
  import hcbp_pkg::*;

  push_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  push_t             head;
  logic [WORD_W-1:0] shifted;
  logic              beat;
  logic              head_done;

  assign head      = slots[rd_ptr];
  assign shifted   = head.word << {idx, 3'b000};
  assign beat      = rsp.valid && rsp.ready;
  assign head_done = (NB_W'(idx) + NB_W'(1) == head.nbytes);

  assign rsp.valid    = (count != '0);
  assign rsp.out_byte = shifted[WORD_W-1 -: BYTE_W];
  assign rsp.last     = head.last && head_done;
  assign level        = count;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (beat) begin
        if (head_done) begin
          idx    <= '0;
          rd_ptr <= rd_ptr + PTR_W'(1);
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(beat && head_done);
    end
  end

endmodule

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Prefix-code bit packer: code table in a 256-entry RAM, pending bits, byte output queue.
// An accepted item is registered with its table read in the lookup stage, then its bytes enter the output queue.
// Throughput: one item per cycle; an encode yielding n bytes holds the output for n beats,
// and the four-group output queue throttles input when those bursts pile up.
// Reset (synchronous, rst high) clears the pending bits, the pipeline and the queue;
// the code table is not cleared and no entry may be encoded before it is loaded.
module huffman_code_bit_packer (
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    req,
  hcbp_out_if.source rsp
);
  import hcbp_pkg::*;

  logic                    accept;
  logic                    in_range;
  logic [LEN_W-1:0]        len_sat;
  logic [MAX_CODE_LEN-1:0] code_in;
  logic [MAX_CODE_LEN-1:0] code_mask;
  logic                    we;
  logic [ENTRY_W-1:0]      wdata;
  logic [ENTRY_W-1:0]      rdata;
  logic                    s1_valid;
  logic [ACTION_W-1:0]     s1_action;
  logic                    s1_in_range;
  push_t                   push;
  logic [CNT_W-1:0]        level;

  // Count the item in the lookup stage as if it will push, so the queue never overflows.
  assign req.ready = (CNT_W'(level) + CNT_W'(s1_valid)) < CNT_W'(FIFO_DEPTH);
  assign accept    = req.valid && req.ready;
  assign in_range  = {1'b0, req.symbol} < 9'(SYMBOL_COUNT);

  assign len_sat   = (req.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                               : req.code_length;
  assign code_in   = MAX_CODE_LEN'(req.code_bits);
  assign code_mask = ~({MAX_CODE_LEN{1'b1}} << len_sat);
  assign wdata     = {code_in & code_mask, len_sat};
  assign we        = accept && (req.action == ACT_LOAD) && in_range;

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_table (
    .clk   (clk),
    .we    (we),
    .waddr (SYM_W'(req.symbol)),
    .wdata (wdata),
    .raddr (SYM_W'(req.symbol)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_action   <= req.action;
    s1_in_range <= in_range;
  end

  hcbp_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_action   (s1_action),
    .s1_in_range (s1_in_range),
    .entry       (rdata),
    .push        (push)
  );

  hcbp_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .level (level),
    .rsp   (rsp)
  );

endmodule

// ===== hw/rtl/hcbp_checker.sv =====
// Port-level checker of the prefix-code bit packer, bound to the top level.
// Depends on huffman_code_bit_packer_macros.svh.
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_out_byte,
  input logic       rsp_last
);

  // A stalled output beat stays offered and unchanged.
  `HCBP_ASSERT(a_out_hold, rsp_valid && !rsp_ready |=> rsp_valid)
  `HCBP_ASSERT(a_out_stable, rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last))
  // Reset empties the output queue.
  `HCBP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !rsp_valid)
  // An empty queue only refills from an accepted item that has passed the lookup stage.
  `HCBP_ASSERT(a_out_cause, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_out_byte (rsp.out_byte),
  .rsp_last     (rsp.last)
);
